### hdl/tqle_pkg.sv
// Shared constants, command codes and control/status structs for the Q-learning engine.
// Used by tqle_ctrl, tqle_dp and the top level tabular_q_learning_engine.
package tqle_pkg;

	localparam int NUM_STATES = 16;
	localparam int ROW_W      = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int NUM_ACT    = 4;
	localparam int VAL_W      = 32;
	localparam int ROW_BITS   = NUM_ACT * VAL_W;

	// Reciprocal for the row modulo: floor(mag * RECIP / 2^32) is at most one below mag / N.
	localparam logic [31:0] ROW_RECIP = 32'((64'd1 << 32) / NUM_STATES);

	localparam logic [31:0] Q_ONE       = 32'h0001_0000;
	localparam logic [15:0] DECAY_MUL   = 16'd64881;
	localparam logic [15:0] RATE_FLOOR  = 16'd655;
	localparam logic [15:0] RATE_RESET  = 16'd6554;
	localparam logic [15:0] ALPHA_RESET = 16'd6554;
	localparam logic [15:0] GAMMA_RESET = 16'd62259;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LEARNING = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT = 1'b1;

	typedef enum logic [1:0] {
		CMD_TRAIN   = 2'd0,
		CMD_PREDICT = 2'd1,
		CMD_GET     = 2'd2,
		CMD_DECAY   = 2'd3
	} cmd_t;

	// One enable per datapath step.
	typedef struct packed {
		logic capture;
		logic mod_mul;
		logic row_fix;
		logic mem_read;
		logic eval;
		logic gmul;
		logic target;
		logic amul;
		logic update;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic train_path;
		logic out_busy;
	} dp_sts_t;

endpackage

### hdl/tqle_dp.sv
// Datapath of the Q-learning engine: config and rate registers, Q table memory,
// row modulo, update arithmetic and output register. Depends on tqle_pkg.
module tqle_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tqle_pkg::dp_cmd_t                   dp_cmd,
	output tqle_pkg::dp_sts_t                   dp_sts,
	input  logic                                cfg_we,
	input  logic [tqle_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [15:0]                         cfg_data,
	input  logic [1:0]                          cmd,
	input  logic                                state_present,
	input  logic signed [15:0]                  state_value,
	input  logic [1:0]                          action,
	input  logic signed [31:0]                  reward,
	input  logic [15:0]                         explore_draw,
	input  logic [1:0]                          explore_action,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [31:0]                  value_a0,
	output logic signed [31:0]                  value_a1,
	output logic signed [31:0]                  value_a2,
	output logic signed [31:0]                  value_a3,
	output logic                                explored,
	output logic [15:0]                         rate_now
);
	import tqle_pkg::*;

	logic [15:0] alpha_q, gamma_q, rate_q;

	cmd_t               cmd_q;
	logic               present_q;
	logic [16:0]        mag_q;
	logic [1:0]         act_q, ract_q;
	logic signed [31:0] reward_q;
	logic [15:0]        draw_q;

	logic [16:0]         qe_q;
	logic [ROW_W-1:0]    row_q;
	logic [ROW_BITS-1:0] mem_q [NUM_STATES];
	logic [ROW_BITS-1:0] rd_row_q;
	logic                rd_vld_q;
	logic [NUM_STATES-1:0] vld_q;

	logic signed [31:0] max_q, q_q;
	logic signed [48:0] prodg_q;
	logic signed [33:0] target_q;
	logic signed [50:0] proda_q;

	logic signed [31:0] res_q [NUM_ACT];
	logic               res_explored_q;
	logic               out_valid_q;

	// combinational
	logic [16:0]        mag_d;
	logic [48:0]        recip_prod;
	logic [16:0]        r_raw, r_fix;
	logic signed [31:0] rv [NUM_ACT];
	logic signed [31:0] max_d;
	logic signed [16:0] gamma_s, alpha_s;
	logic signed [35:0] nq;
	logic signed [31:0] nq_sat;
	logic [ROW_BITS-1:0] wr_row;
	logic [31:0]        dec_prod;
	logic [15:0]        dec_rate;
	logic signed [31:0] res_d [NUM_ACT];
	logic               res_expl_d;

	// |state_value| in 17 bits: the most negative input maps to 32768
	assign mag_d      = state_value[15] ? (17'd0 - 17'($signed(state_value))) :
	                                      {1'b0, state_value};
	assign recip_prod = 49'(mag_q) * 49'(ROW_RECIP);
	assign r_raw      = mag_q - 17'(qe_q * 17'(NUM_STATES));
	assign r_fix      = (r_raw >= 17'(NUM_STATES)) ? (r_raw - 17'(NUM_STATES)) : r_raw;

	always_comb begin
		for (int i = 0; i < NUM_ACT; i++) begin
			rv[i] = rd_vld_q ? $signed(rd_row_q[i*VAL_W +: VAL_W]) : 32'sd0;
		end
		max_d = rv[0];
		for (int i = 1; i < NUM_ACT; i++) begin
			if (rv[i] > max_d) begin
				max_d = rv[i];
			end
		end
	end

	assign gamma_s = $signed({1'b0, gamma_q});
	assign alpha_s = $signed({1'b0, alpha_q});

	// floor(alpha * target / 2^16) is the arithmetic shift of the product
	assign nq = 36'(q_q) + 36'($signed(proda_q[50:16]));

	always_comb begin
		if (nq[35:31] != {5{nq[35]}}) begin
			nq_sat = nq[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			nq_sat = nq[31:0];
		end
		for (int i = 0; i < NUM_ACT; i++) begin
			wr_row[i*VAL_W +: VAL_W] = (act_q == 2'(i)) ? nq_sat : rv[i];
		end
	end

	assign dec_prod = 32'(rate_q) * 32'(DECAY_MUL);
	assign dec_rate = (dec_prod[31:16] < RATE_FLOOR) ? RATE_FLOOR : dec_prod[31:16];

	// config and rate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
			gamma_q <= GAMMA_RESET;
			rate_q  <= RATE_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LEARNING: alpha_q <= cfg_data;
					REG_DISCOUNT: gamma_q <= cfg_data;
					default: ;
				endcase
			end
			if (dp_cmd.eval && cmd_q == CMD_DECAY) begin
				rate_q <= dec_rate;
			end
		end
	end

	// item capture and arithmetic steps
	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			cmd_q     <= cmd_t'(cmd);
			present_q <= state_present;
			mag_q     <= mag_d;
			act_q     <= action;
			reward_q  <= reward;
			draw_q    <= explore_draw;
			ract_q    <= explore_action;
		end
		if (dp_cmd.mod_mul) begin
			qe_q <= recip_prod[48:32];
		end
		if (dp_cmd.row_fix) begin
			row_q <= r_fix[ROW_W-1:0];
		end
		if (dp_cmd.eval) begin
			max_q <= max_d;
			q_q   <= rv[act_q];
		end
		if (dp_cmd.gmul) begin
			prodg_q <= 49'(max_q) * 49'(gamma_s);
		end
		if (dp_cmd.target) begin
			target_q <= 34'(reward_q) + 34'($signed(prodg_q[48:16])) - 34'(q_q);
		end
		if (dp_cmd.amul) begin
			proda_q <= 51'(target_q) * 51'(alpha_s);
		end
	end

	// result of predict and get; train and decay leave it zero
	always_comb begin
		for (int i = 0; i < NUM_ACT; i++) begin
			res_d[i] = 32'sd0;
		end
		res_expl_d = 1'b0;
		if (present_q) begin
			case (cmd_q)
				CMD_PREDICT: begin
					if (draw_q < rate_q) begin
						for (int i = 0; i < NUM_ACT; i++) begin
							res_d[i] = (ract_q == 2'(i)) ? $signed(Q_ONE) : 32'sd0;
						end
						res_expl_d = 1'b1;
					end else begin
						for (int i = 0; i < NUM_ACT; i++) begin
							res_d[i] = rv[i];
						end
					end
				end
				CMD_GET: res_d[0] = rv[act_q];
				default: ;
			endcase
		end
	end

	// result staging
	always_ff @(posedge clk) begin
		if (dp_cmd.update) begin
			res_q[0] <= nq_sat;
			for (int i = 1; i < NUM_ACT; i++) begin
				res_q[i] <= 32'sd0;
			end
			res_explored_q <= 1'b0;
		end else if (dp_cmd.eval) begin
			for (int i = 0; i < NUM_ACT; i++) begin
				res_q[i] <= res_d[i];
			end
			res_explored_q <= res_expl_d;
		end
	end

	// Q table: one row of four entries per state, registered read
	always_ff @(posedge clk) begin
		if (dp_cmd.mem_read) begin
			rd_row_q <= mem_q[row_q];
			rd_vld_q <= vld_q[row_q];
		end
		if (dp_cmd.update) begin
			mem_q[row_q] <= wr_row;
		end
	end

	// rows never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (dp_cmd.update) begin
			vld_q[row_q] <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load_out) begin
			value_a0 <= res_q[0];
			value_a1 <= res_q[1];
			value_a2 <= res_q[2];
			value_a3 <= res_q[3];
			explored <= res_explored_q;
			rate_now <= rate_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign dp_sts.out_busy   = out_valid_q && out_stall;
	assign dp_sts.train_path = (cmd_q == CMD_TRAIN) && present_q;

endmodule

### hdl/tqle_ctrl.sv
// Controller of the Q-learning engine: one-hot sequencer that steps the datapath.
// Depends on tqle_pkg.
module tqle_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  tqle_pkg::dp_sts_t    dp_sts,
	output tqle_pkg::dp_cmd_t    dp_cmd
);
	import tqle_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_MOD  = 10'b00_0000_0010,
		S_ROW  = 10'b00_0000_0100,
		S_READ = 10'b00_0000_1000,
		S_EVAL = 10'b00_0001_0000,
		S_GMUL = 10'b00_0010_0000,
		S_TGT  = 10'b00_0100_0000,
		S_AMUL = 10'b00_1000_0000,
		S_UPD  = 10'b01_0000_0000,
		S_OUT  = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		dp_cmd  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					dp_cmd.capture = 1'b1;
					state_d        = S_MOD;
				end
			end
			S_MOD: begin
				dp_cmd.mod_mul = 1'b1;
				state_d        = S_ROW;
			end
			S_ROW: begin
				dp_cmd.row_fix = 1'b1;
				state_d        = S_READ;
			end
			S_READ: begin
				dp_cmd.mem_read = 1'b1;
				state_d         = S_EVAL;
			end
			S_EVAL: begin
				dp_cmd.eval = 1'b1;
				state_d     = dp_sts.train_path ? S_GMUL : S_OUT;
			end
			S_GMUL: begin
				dp_cmd.gmul = 1'b1;
				state_d     = S_TGT;
			end
			S_TGT: begin
				dp_cmd.target = 1'b1;
				state_d       = S_AMUL;
			end
			S_AMUL: begin
				dp_cmd.amul = 1'b1;
				state_d     = S_UPD;
			end
			S_UPD: begin
				dp_cmd.update = 1'b1;
				state_d       = S_OUT;
			end
			S_OUT: begin
				// hold the result until the output register frees up
				if (!dp_sts.out_busy) begin
					dp_cmd.load_out = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

### hdl/tabular_q_learning_engine.sv
// Top level of the tabular Q-learning engine with epsilon-greedy selection.
// Instantiates tqle_ctrl and tqle_dp; depends on tqle_pkg.
//
//  channel   direction  handshake            payload
//  in        sink       in_valid / in_stall  cmd, state_present, state_value, action,
//                                            reward, explore_draw, explore_action
//  out       source     out_valid/out_stall  value_a0..value_a3, explored, rate_now
//  cfg       sink       cfg_we               cfg_index, cfg_data (no read-back)
//
// One item at a time: after accept, predict, get and decay step row modulo, table read
// and max, then load the result; train adds two chained multiplies and write-back before
// its result load. The next item is taken only once the result has loaded. The
// single-port row read and write of the Q table and the multiply chain keep items apart.
// A result waits in the output register while out_stall is high; the next item is
// taken meanwhile and holds before its own result load.
// Reset clears the table (per-row valid bits) and sets the rate and the gains to their reset values at once.
module tabular_q_learning_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      cmd,
	input  logic                            state_present,
	input  logic signed [15:0]              state_value,
	input  logic [1:0]                      action,
	input  logic signed [31:0]              reward,
	input  logic [15:0]                     explore_draw,
	input  logic [1:0]                      explore_action,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [31:0]              value_a0,
	output logic signed [31:0]              value_a1,
	output logic signed [31:0]              value_a2,
	output logic signed [31:0]              value_a3,
	output logic                            explored,
	output logic [15:0]                     rate_now,
	input  logic                            cfg_we,
	input  logic [tqle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                     cfg_data
);
	import tqle_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	tqle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.dp_sts   (dp_sts),
		.dp_cmd   (dp_cmd)
	);

	tqle_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.dp_cmd         (dp_cmd),
		.dp_sts         (dp_sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.state_present  (state_present),
		.state_value    (state_value),
		.action         (action),
		.reward         (reward),
		.explore_draw   (explore_draw),
		.explore_action (explore_action),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.value_a0       (value_a0),
		.value_a1       (value_a1),
		.value_a2       (value_a2),
		.value_a3       (value_a3),
		.explored       (explored),
		.rate_now       (rate_now)
	);

endmodule
